/* hdl/rhns_pkg.sv */
// ----------------------------------------------------------------------------
// rhns_pkg
// Shared types, codes and MD5 tables for the rendezvous hash node selector.
// ----------------------------------------------------------------------------
package rhns_pkg;

    localparam int ID_W     = 128;
    localparam int WEIGHT_W = 64;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_NOT_PRESENT = 3'd3,
        ST_NO_MATCH    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_HASH,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic inc_idx;
        logic cmp;
        logic hash_start;
        logic hash_step;
        logic fin;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic lookup;
        logic cur_valid;
        logic round_last;
        logic out_busy;
    } dp_stat_t;

    localparam logic [31:0] MD5_A0 = 32'h67452301;
    localparam logic [31:0] MD5_B0 = 32'hefcdab89;
    localparam logic [31:0] MD5_C0 = 32'h98badcfe;
    localparam logic [31:0] MD5_D0 = 32'h10325476;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // message word index for round i (all arithmetic mod 16)
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = {i[1:0], 2'b00} + i[3:0] + 4'd1;
            2'd2:    g = {i[2:0], 1'b0} + i[3:0] + 4'd5;
            default: g = {i[0], 3'b000} - i[3:0];
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [5:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (i[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

/* hdl/rhns_ram.sv */
// ----------------------------------------------------------------------------
// rhns_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rhns_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/rhns_ctrl.sv */
// ----------------------------------------------------------------------------
// rhns_ctrl
// Sequencer: slot scan, per-slot MD5 rounds and result hand-off.
// ----------------------------------------------------------------------------
module rhns_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rhns_pkg::dp_stat_t   stat,
    output rhns_pkg::ctrl_cmd_t  cmd
);

    import rhns_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_CMP;
            S_CMP:
            begin
                if (stat.lookup && stat.cur_valid)
                begin
                    state_next = S_HASH;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_HASH:
            begin
                if (stat.round_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:  state_next = stat.idx_last ? S_DONE : S_READ;
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CMP:
            begin
                cmd.cmp        = 1'b1;
                cmd.hash_start = stat.lookup && stat.cur_valid;
                cmd.inc_idx    = !(stat.lookup && stat.cur_valid) && !stat.idx_last;
            end
            S_HASH: cmd.hash_step = 1'b1;
            S_FIN:
            begin
                cmd.fin     = 1'b1;
                cmd.inc_idx = !stat.idx_last;
            end
            S_DONE: cmd.commit = !stat.out_busy;
            default: ;
        endcase
    end

endmodule

/* hdl/rhns_dp.sv */
// ----------------------------------------------------------------------------
// rhns_dp
// Datapath: node table, MD5 round unit, best-weight tracking, result register.
// ----------------------------------------------------------------------------
module rhns_dp #(
    parameter int MAX_NODES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rhns_pkg::ctrl_cmd_t  cmd,
    output rhns_pkg::dp_stat_t   stat,
    input  logic [1:0]           in_req,
    input  logic [255:0]         in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_status,
    output logic [191:0]         out_data
);

    import rhns_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [1:0]          req_reg;
    logic [63:0]         nh_reg, nl_reg, kh_reg, kl_reg;
    logic [IW-1:0]       idx_reg;
    logic [MAX_NODES-1:0] valid_reg;
    logic                have_match_reg, have_free_reg, found_reg;
    logic [IW-1:0]       match_idx_reg, free_idx_reg;
    logic [ID_W-1:0]     cur_id_reg, chosen_reg;
    logic [WEIGHT_W-1:0] best_reg;
    logic [31:0]         a_reg, b_reg, c_reg, d_reg;
    logic [5:0]          rnd_reg;
    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [191:0]        out_data_reg;

    logic [ID_W-1:0]     rdata;
    logic                cur_valid, ram_we;
    logic [31:0]         m_word, sum, rot, b_next;
    logic [4:0]          sh;
    logic [WEIGHT_W-1:0] weight;

    rhns_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES), .AW(IW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({nh_reg, nl_reg}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign cur_valid = valid_reg[idx_reg];
    assign ram_we    = cmd.commit && (req_reg == REQ_ADD) && !have_match_reg && have_free_reg;

    assign stat.idx_last   = (idx_reg == IW'(MAX_NODES - 1));
    assign stat.lookup     = (req_reg == REQ_LOOKUP);
    assign stat.cur_valid  = cur_valid;
    assign stat.round_last = (rnd_reg == 6'd63);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // block words: node||key big-endian bytes, 0x80 pad, length 256 bits
    always_comb
    begin
        case (md5_g(rnd_reg))
            4'd0:    m_word = bswap32(cur_id_reg[127:96]);
            4'd1:    m_word = bswap32(cur_id_reg[95:64]);
            4'd2:    m_word = bswap32(cur_id_reg[63:32]);
            4'd3:    m_word = bswap32(cur_id_reg[31:0]);
            4'd4:    m_word = bswap32(kh_reg[63:32]);
            4'd5:    m_word = bswap32(kh_reg[31:0]);
            4'd6:    m_word = bswap32(kl_reg[63:32]);
            4'd7:    m_word = bswap32(kl_reg[31:0]);
            4'd8:    m_word = 32'h0000_0080;
            4'd14:   m_word = 32'h0000_0100;
            default: m_word = 32'h0;
        endcase
    end

    assign sum    = a_reg + md5_f(rnd_reg, b_reg, c_reg, d_reg) + MD5_K[rnd_reg] + m_word;
    assign sh     = MD5_S[{rnd_reg[5:4], rnd_reg[1:0]}];
    assign rot    = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    assign b_next = b_reg + rot;
    assign weight = {b_reg + MD5_B0, a_reg + MD5_A0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.commit && (req_reg == REQ_REMOVE) && have_match_reg)
            begin
                valid_reg[match_idx_reg] <= 1'b0;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg        <= in_req;
            nh_reg         <= in_data[63:0];
            nl_reg         <= in_data[127:64];
            kh_reg         <= in_data[191:128];
            kl_reg         <= in_data[255:192];
            idx_reg        <= '0;
            have_match_reg <= 1'b0;
            have_free_reg  <= 1'b0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            chosen_reg     <= '0;
        end
        if (cmd.inc_idx)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.cmp)
        begin
            cur_id_reg <= rdata;
            if (cur_valid && rdata == {nh_reg, nl_reg} && !have_match_reg)
            begin
                have_match_reg <= 1'b1;
                match_idx_reg  <= idx_reg;
            end
            if (!cur_valid && !have_free_reg)
            begin
                have_free_reg <= 1'b1;
                free_idx_reg  <= idx_reg;
            end
        end
        if (cmd.hash_start)
        begin
            a_reg   <= MD5_A0;
            b_reg   <= MD5_B0;
            c_reg   <= MD5_C0;
            d_reg   <= MD5_D0;
            rnd_reg <= '0;
        end
        if (cmd.hash_step)
        begin
            a_reg   <= d_reg;
            d_reg   <= c_reg;
            c_reg   <= b_reg;
            b_reg   <= b_next;
            rnd_reg <= rnd_reg + 6'd1;
        end
        // strict compare keeps the lower slot on a tie
        if (cmd.fin && weight > best_reg)
        begin
            best_reg   <= weight;
            chosen_reg <= cur_id_reg;
            found_reg  <= 1'b1;
        end
        if (cmd.commit)
        begin
            case (req_reg)
                REQ_ADD:
                begin
                    out_data_reg <= '0;
                    if (have_match_reg)
                        out_status_reg <= ST_DUPLICATE;
                    else if (!have_free_reg)
                        out_status_reg <= ST_FULL;
                    else
                        out_status_reg <= ST_OK;
                end
                REQ_REMOVE:
                begin
                    out_data_reg   <= '0;
                    out_status_reg <= have_match_reg ? ST_OK : ST_NOT_PRESENT;
                end
                REQ_LOOKUP:
                begin
                    out_status_reg <= found_reg ? ST_OK : ST_NO_MATCH;
                    out_data_reg   <= {best_reg, chosen_reg[63:0], chosen_reg[127:64]};
                end
                default:
                begin
                    out_data_reg   <= '0;
                    out_status_reg <= ST_OK;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

endmodule

/* hdl/rendezvous_hash_node_selector_unit.sv */
// ----------------------------------------------------------------------------
// rendezvous_hash_node_selector_unit
// Highest-random-weight node selector over a table of 128-bit node IDs.
// ----------------------------------------------------------------------------
// One request beat in on the s_ side (tuser = request kind, tdata = node and
// key), one result beat out on the m_ side (tuser = status, tdata = chosen
// node and weight). Requests are handled one at a time.
// Every request scans all MAX_NODES slots of the ID RAM, each slot as a
// registered read then a compare. A lookup adds, for each valid slot, 64 MD5
// rounds of one round per cycle plus a step to fold and compare the weight.
// Lookup time grows with the number of valid nodes, since the single MD5
// round unit hashes one slot at a time.
// The result sits in an output register; s_tready returns once it is loaded,
// so the next request is taken while the result waits. If m_tready stays low,
// the next request completes its scan and then holds until the result beat
// is taken.
// Reset clears all slot valid bits and the output valid; the ID RAM is not
// cleared.
// ----------------------------------------------------------------------------
module rendezvous_hash_node_selector_unit #(
    parameter int MAX_NODES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // req_type
    input  logic [255:0] s_tdata,   // node_hi, node_lo, key_hi, key_lo
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // status
    output logic [191:0] m_tdata    // chosen_hi, chosen_lo, best_weight
);

    import rhns_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rhns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rhns_dp #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_tuser),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_NO_MATCH)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("failed request carries nonzero payload");
`endif

endmodule
